### hw/rtl/u8d_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared types and constants of the UTF-8 to code unit decoder.
// ----------------------------------------------------------------------------
package u8d_pkg;

    localparam int UnitWidth = 21;
    localparam int MaxUnits  = 4;

    typedef logic [UnitWidth-1:0] unit_t;

    // Results produced by one input byte, in order from units[0]
    typedef struct packed {
        unit_t [MaxUnits-1:0] units;
        logic  [2:0]          count;
    } u8d_result_t;

    localparam unit_t QMARK_UNIT   = 21'd63;
    localparam unit_t SUPP_OFFSET  = 21'h10000;
    localparam logic [5:0] HI_SURR_TAG = 6'b110110;   // 0xD800 >> 10
    localparam logic [5:0] LO_SURR_TAG = 6'b110111;   // 0xDC00 >> 10

endpackage
`default_nettype wire

### hw/rtl/utf8_to_code_unit_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_to_code_unit_decoder
// UTF-8 byte stream in, code points or UTF-16 code units out.
// ----------------------------------------------------------------------------
// Takes one byte per transfer and accepts a byte every cycle while each byte
// yields at most one unit and m_tready stays high. A byte that yields n units
// (a surrogate pair, or replacements when the string ends inside a sequence)
// holds the result register, draining one unit per cycle while m_tready is
// high, and holds back the next byte until its last unit is taken. A byte
// goes through the input register, then decode into the result register.
// Multi-byte leads and incomplete sequences yield nothing until the sequence
// closes; s_tlast forces it to close. Write cfg_data only while idle.
// ----------------------------------------------------------------------------
module utf8_to_code_unit_decoder
    import u8d_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // end_of_string
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [20:0] code_unit, [23:21] zero
    output logic        m_tlast,   // last_of_run
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data   // sixteen_bit_units
);

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_eos_reg;
    logic        mode_reg;
    logic        can_load;
    logic        fire;
    logic [1:0]  held_count;
    u8d_result_t dec_result;

    assign fire      = in_valid_reg && can_load;
    assign s_tready  = !in_valid_reg || fire;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            mode_reg     <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                in_valid_reg <= 1'b1;
            else if (fire)
                in_valid_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
                mode_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_eos_reg  <= s_tlast;
        end
    end

    u8d_decode u_decode (
        .clk               (clk),
        .rst_n             (rst_n),
        .fire              (fire),
        .data_byte         (in_byte_reg),
        .end_of_string     (in_eos_reg),
        .sixteen_bit_units (mode_reg),
        .result            (dec_result),
        .held_count        (held_count)
    );

    u8d_out_buf u_out_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (fire),
        .result   (dec_result),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // A held byte must move on as soon as the result register is empty
    a_drain : assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !m_tvalid |-> fire)
        else $error("input byte stalled with empty result register");

    // The end of a string always yields at least one unit
    a_eos_emits : assert property (@(posedge clk) disable iff (!rst_n)
        fire && in_eos_reg |-> dec_result.count != 3'd0)
        else $error("end of string produced no unit");

    // The end of a string leaves no sequence pending
    a_eos_clears : assert property (@(posedge clk) disable iff (!rst_n)
        fire && in_eos_reg |=> held_count == 2'd0)
        else $error("sequence state not cleared at end of string");

endmodule
`default_nettype wire

### hw/rtl/u8d_decode.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u8d_decode
// Sequence tracking state and the combinational decode of one byte.
// ----------------------------------------------------------------------------
module u8d_decode
    import u8d_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fire,
    input  logic [7:0]  data_byte,
    input  logic        end_of_string,
    input  logic        sixteen_bit_units,
    output u8d_result_t result,
    output logic [1:0]  held_count
);

    logic [7:0] held_reg [3];
    logic [1:0] held_count_reg;
    logic [1:0] needed_reg;

    logic [7:0] seq_buf [4];
    logic [2:0] byte_total;
    logic [2:0] lead_len_b;
    logic       finish;
    unit_t [MaxUnits-1:0] units;
    logic [2:0] unit_count;

    // Sequence length of a lead byte, 0 when the byte cannot lead
    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] len;
        begin
            if (b[7] == 1'b0)
                len = 3'd1;
            else if (b[7:5] == 3'b110)
                len = 3'd2;
            else if (b[7:4] == 4'b1110)
                len = 3'd3;
            else if (b[7:3] == 5'b11110)
                len = 3'd4;
            else
                len = 3'd0;
            return len;
        end
    endfunction

    function automatic unit_t seq_value(input logic [7:0] a0, input logic [7:0] a1,
                                        input logic [7:0] a2, input logic [7:0] a3,
                                        input logic [2:0] len);
        unit_t cp;
        begin
            case (len)
                3'd1:    cp = {13'd0, a0};
                3'd2:    cp = {10'd0, a0[4:0], a1[5:0]};
                3'd3:    cp = {5'd0, a0[3:0], a1[5:0], a2[5:0]};
                default: cp = {a0[2:0], a1[5:0], a2[5:0], a3[5:0]};
            endcase
            return cp;
        end
    endfunction

    always_comb
    begin
        seq_buf[0] = (held_count_reg > 2'd0) ? held_reg[0] : data_byte;
        seq_buf[1] = (held_count_reg > 2'd1) ? held_reg[1] : data_byte;
        seq_buf[2] = (held_count_reg > 2'd2) ? held_reg[2] : data_byte;
        seq_buf[3] = data_byte;
        byte_total = {1'b0, held_count_reg} + 3'd1;
        lead_len_b = lead_length(data_byte);
        if (held_count_reg == 2'd0)
            finish = (lead_len_b < 3'd2) || end_of_string;
        else
            finish = (needed_reg <= 2'd1) || end_of_string;
    end

    // Decode the buffered bytes as a string that ends here; a lead whose
    // sequence does not fit gives a replacement and the next byte leads.
    always_comb
    begin : tail_decode
        logic [2:0] pos;
        logic [2:0] len;
        logic [1:0] p;
        unit_t      cp;
        unit_t      supp;
        pos        = 3'd0;
        len        = 3'd0;
        p          = 2'd0;
        cp         = '0;
        supp       = '0;
        unit_count = 3'd0;
        units      = '0;
        for (int step = 0; step < 4; step++)
        begin
            if (pos < byte_total)
            begin
                p   = pos[1:0];
                len = lead_length(seq_buf[p]);
                if (len == 3'd0 || (pos + len) > byte_total)
                begin
                    units[unit_count[1:0]] = QMARK_UNIT;
                    unit_count = unit_count + 3'd1;
                    pos = pos + 3'd1;
                end
                else
                begin
                    cp = seq_value(seq_buf[p], seq_buf[p + 2'd1], seq_buf[p + 2'd2],
                                   seq_buf[p + 2'd3], len);
                    supp = cp - SUPP_OFFSET;
                    if (len == 3'd4 && sixteen_bit_units && cp[20:16] != 5'd0)
                    begin
                        units[unit_count[1:0]] = {5'd0, HI_SURR_TAG, supp[19:10]};
                        units[unit_count[1:0] + 2'd1] = {5'd0, LO_SURR_TAG, supp[9:0]};
                        unit_count = unit_count + 3'd2;
                    end
                    else
                    begin
                        units[unit_count[1:0]] = cp;
                        unit_count = unit_count + 3'd1;
                    end
                    pos = pos + len;
                end
            end
        end
    end

    assign result.units = units;
    assign result.count = finish ? unit_count : 3'd0;
    assign held_count   = held_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count_reg <= 2'd0;
            needed_reg     <= 2'd0;
        end
        else if (fire)
        begin
            if (finish)
            begin
                held_count_reg <= 2'd0;
                needed_reg     <= 2'd0;
            end
            else
            begin
                if (held_count_reg != 2'd3)
                    held_count_reg <= held_count_reg + 2'd1;
                if (held_count_reg == 2'd0)
                    needed_reg <= 2'(lead_len_b - 3'd1);
                else
                    needed_reg <= needed_reg - 2'd1;
            end
        end
    end

    // Held bytes are payload: only the first held_count entries are read
    always_ff @(posedge clk)
    begin
        if (fire && !finish && held_count_reg != 2'd3)
            held_reg[held_count_reg] <= data_byte;
    end

endmodule
`default_nettype wire

### hw/rtl/u8d_out_buf.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u8d_out_buf
// Result register: holds the units of one byte and shifts them out in order.
// ----------------------------------------------------------------------------
module u8d_out_buf
    import u8d_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  u8d_result_t result,
    output logic        can_load,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [20:0] code_unit, [23:21] zero
    output logic        m_tlast    // last_of_run
);

    unit_t [MaxUnits-1:0] units_reg;
    logic  [2:0]          remaining_reg;
    logic                 take;

    assign m_tvalid = (remaining_reg != 3'd0);
    assign m_tlast  = (remaining_reg == 3'd1);
    assign m_tdata  = {3'd0, units_reg[0]};
    assign take     = m_tvalid && m_tready;
    assign can_load = !m_tvalid || (m_tlast && m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            remaining_reg <= 3'd0;
        else if (load)
            remaining_reg <= result.count;
        else if (take)
            remaining_reg <= remaining_reg - 3'd1;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            units_reg <= result.units;
        else if (take)
            units_reg[MaxUnits-2:0] <= units_reg[MaxUnits-1:1];
    end

endmodule
`default_nettype wire
